@@ rtl/sgp_pkg.sv @@
// Shared types and constants for the selective grayscale pixel block.
// Used by sgp_front, sgp_fifo, sgp_back and the top level; no dependencies.
package sgp_pkg;

    localparam int CH_W           = 8;
    localparam int HUE_W          = 9;
    localparam int NUM_W          = 17;
    localparam int CFG_W          = 9;
    localparam int LUMA_W         = 24;
    localparam int HUE_DIV_STAGES = 9;
    localparam int OUT_DIV_STAGES = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Q0.16 luminance weights, summing to one
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    // floor(2^32 / 255), used for divide-by-255 with one correction step
    localparam logic [24:0] RECIP_255 = 25'h1010101;
    localparam logic [8:0]  FULL_ALPHA = 9'd255;

    localparam logic [CFG_W-1:0] TARGET_HUE_RST = 9'd0;
    localparam logic [CFG_W-1:0] HUE_SPREAD_RST = 9'd30;

    typedef enum logic {
        CFG_TARGET_HUE = 1'b0,
        CFG_HUE_SPREAD = 1'b1
    } cfg_index_t;

    // Classified pixel: channels, hue numerator and max-min denominator
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic [NUM_W-1:0] num;
        logic [CH_W-1:0]  dl;
    } sgp_item_t;

endpackage

@@ rtl/sgp_front.sv @@
// Front end: accepts input words, finds max/min channel and hue sector.
// Depends on sgp_pkg.
module sgp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sgp_pkg::CH_W-1:0]    red_in,
    input  logic [sgp_pkg::CH_W-1:0]    green_in,
    input  logic [sgp_pkg::CH_W-1:0]    blue_in,
    input  logic [sgp_pkg::CH_W-1:0]    alpha_in,
    output logic                        q_valid,
    input  logic                        q_ready,
    output sgp_pkg::sgp_item_t          q_item
);

    logic               fr_valid_reg;
    sgp_pkg::sgp_item_t fr_item_reg;
    sgp_pkg::sgp_item_t fr_item_next;

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         dl;
    logic signed [18:0] rs, gs, bs, dls, num_s;

    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        dl  = mx - mn;
        rs  = {11'b0, red_in};
        gs  = {11'b0, green_in};
        bs  = {11'b0, blue_in};
        dls = {11'b0, dl};
        if (dl == 8'd0)
        begin
            num_s = '0;
        end
        else if (mx == red_in)
        begin
            num_s = 19'sd60 * (gs - bs);
            if (num_s < 0)
                num_s = num_s + 19'sd360 * dls;
        end
        else if (mx == green_in)
        begin
            num_s = 19'sd120 * dls + 19'sd60 * (bs - rs);
        end
        else
        begin
            num_s = 19'sd240 * dls + 19'sd60 * (rs - gs);
        end
        fr_item_next.red   = red_in;
        fr_item_next.green = green_in;
        fr_item_next.blue  = blue_in;
        fr_item_next.alpha = alpha_in;
        fr_item_next.num   = num_s[16:0];
        // grey pixel: divide 0 by 1 so the hue comes out 0
        fr_item_next.dl    = (dl == 8'd0) ? 8'd1 : dl;
    end

    assign in_ready = !fr_valid_reg || q_ready;
    assign q_valid  = fr_valid_reg;
    assign q_item   = fr_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            fr_valid_reg <= 1'b1;
        else if (q_ready)
            fr_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            fr_item_reg <= fr_item_next;
    end

endmodule

@@ rtl/sgp_fifo.sv @@
// Short queue between front and back ends, register based.
// Depends on sgp_pkg for the item type.
module sgp_fifo #(
    parameter int DEPTH = sgp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  sgp_pkg::sgp_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sgp_pkg::sgp_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgp_pkg::sgp_item_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/sgp_back.sv @@
// Back end: pipelined hue divide, blend weight, luminance and blend divide.
// Depends on sgp_pkg; all stages advance together on one enable.
module sgp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sgp_pkg::sgp_item_t          s_item,
    input  logic [sgp_pkg::CFG_W-1:0]   target_hue,
    input  logic [sgp_pkg::CFG_W-1:0]   hue_spread,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sgp_pkg::CH_W-1:0]    red_out,
    output logic [sgp_pkg::CH_W-1:0]    green_out,
    output logic [sgp_pkg::CH_W-1:0]    blue_out,
    output logic [sgp_pkg::CH_W-1:0]    alpha_out
);

    localparam int NH      = sgp_pkg::HUE_DIV_STAGES;
    localparam int ND      = sgp_pkg::OUT_DIV_STAGES;
    localparam int NUM_W   = sgp_pkg::NUM_W;
    localparam int HUE_W   = sgp_pkg::HUE_W;
    localparam int ST_W    = NH;
    localparam int ST_M1   = NH + 1;
    localparam int ST_M2   = NH + 2;
    localparam int ST_M3   = NH + 3;
    localparam int ST_DIV0 = NH + 4;
    localparam int NST     = NH + 4 + ND;

    logic [NST-1:0] v_reg;
    logic           adv;

    assign adv       = !v_reg[NST-1] || out_ready;
    assign s_ready   = adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], s_valid};
    end

    // hue divider: one quotient bit per stage, remainder kept in num
    sgp_pkg::sgp_item_t hit_reg [NH];
    logic [HUE_W-1:0]   hq_reg  [NH];
    sgp_pkg::sgp_item_t hit_src [NH];
    logic [HUE_W-1:0]   hq_src  [NH];
    sgp_pkg::sgp_item_t hit_next[NH];
    logic [HUE_W-1:0]   hq_next [NH];

    always_comb
    begin
        logic [NUM_W-1:0] dsh;
        hit_src[0] = s_item;
        hq_src[0]  = '0;
        for (int j = 1; j < NH; j++)
        begin
            hit_src[j] = hit_reg[j-1];
            hq_src[j]  = hq_reg[j-1];
        end
        for (int j = 0; j < NH; j++)
        begin
            dsh         = NUM_W'(hit_src[j].dl) << (NH - 1 - j);
            hit_next[j] = hit_src[j];
            if (hit_src[j].num >= dsh)
            begin
                hit_next[j].num = hit_src[j].num - dsh;
                hq_next[j]      = {hq_src[j][HUE_W-2:0], 1'b1};
            end
            else
            begin
                hq_next[j] = {hq_src[j][HUE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < NH; j++)
            begin
                hit_reg[j] <= hit_next[j];
                hq_reg[j]  <= hq_next[j];
            end
        end
    end

    // weight and luminance stage
    sgp_pkg::sgp_item_t px_w;
    logic [HUE_W-1:0]   hue;
    logic [8:0]         diff;
    logic [8:0]         wn_next, wd_next;
    logic [23:0]        lum_next;

    assign px_w = hit_reg[NH-1];
    assign hue  = hq_reg[NH-1];

    always_comb
    begin
        diff = (target_hue >= hue) ? target_hue - hue : hue - target_hue;
        if (hue_spread == '0)
        begin
            wn_next = (diff == '0) ? 9'd0 : 9'd1;
            wd_next = 9'd1;
        end
        else if (diff <= hue_spread)
        begin
            wn_next = diff;
            wd_next = hue_spread;
        end
        else
        begin
            wn_next = 9'd1;
            wd_next = 9'd1;
        end
        lum_next = 24'(sgp_pkg::LUMA_WR * px_w.red)
                 + 24'(sgp_pkg::LUMA_WG * px_w.green)
                 + 24'(sgp_pkg::LUMA_WB * px_w.blue);
    end

    logic [8:0]  w_wn_reg, w_wd_reg;
    logic [23:0] w_lum_reg;
    logic [7:0]  w_ch_reg [4];

    logic [31:0] m1_al_reg;
    logic [8:0]  m1_wn_reg, m1_wd_reg, m1_wdn_reg;
    logic [7:0]  m1_ch_reg [4];

    logic [24:0] m2_p_reg;
    logic [16:0] m2_ct_reg [4];
    logic [8:0]  m2_wd_reg;

    logic [16:0] m3_qe_reg;
    logic [24:0] m3_p_reg;
    logic [16:0] m3_ct_reg [4];
    logic [8:0]  m3_wd_reg;

    logic [16:0] t_next [4];
    logic [24:0] r255;
    logic [16:0] grey;
    logic [40:0] wal;
    logic [49:0] qprod;

    always_comb
    begin
        wal   = 41'(m1_wn_reg) * 41'(m1_al_reg);
        qprod = 50'(m2_p_reg) * 50'(sgp_pkg::RECIP_255);
        // the estimate is at most one short of the true quotient
        r255  = m3_p_reg - 25'(m3_qe_reg) * 25'd255;
        grey  = (r255 >= 25'd255) ? m3_qe_reg + 17'd1 : m3_qe_reg;
        for (int i = 0; i < 3; i++)
            t_next[i] = m3_ct_reg[i] + grey;
        t_next[3] = m3_ct_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_wn_reg    <= wn_next;
            w_wd_reg    <= wd_next;
            w_lum_reg   <= lum_next;
            w_ch_reg[0] <= px_w.red;
            w_ch_reg[1] <= px_w.green;
            w_ch_reg[2] <= px_w.blue;
            w_ch_reg[3] <= px_w.alpha;

            m1_al_reg  <= 32'(w_ch_reg[3]) * 32'(w_lum_reg);
            m1_wn_reg  <= w_wn_reg;
            m1_wd_reg  <= w_wd_reg;
            m1_wdn_reg <= w_wd_reg - w_wn_reg;
            for (int i = 0; i < 4; i++)
                m1_ch_reg[i] <= w_ch_reg[i];

            m2_p_reg  <= wal[40:16];
            for (int i = 0; i < 3; i++)
                m2_ct_reg[i] <= 17'(m1_wdn_reg) * 17'(m1_ch_reg[i]);
            m2_ct_reg[3] <= 17'(m1_wdn_reg) * 17'(m1_ch_reg[3])
                          + 17'(m1_wn_reg) * 17'(sgp_pkg::FULL_ALPHA);
            m2_wd_reg <= m1_wd_reg;

            m3_qe_reg <= qprod[48:32];
            m3_p_reg  <= m2_p_reg;
            for (int i = 0; i < 4; i++)
                m3_ct_reg[i] <= m2_ct_reg[i];
            m3_wd_reg <= m2_wd_reg;
        end
    end

    // blend divider: four dividends share one divisor, one bit per stage
    logic [16:0] d_rem_reg [ND][4];
    logic [7:0]  d_q_reg   [ND][4];
    logic [8:0]  d_wd_reg  [ND];
    logic [16:0] d_rem_src [ND][4];
    logic [7:0]  d_q_src   [ND][4];
    logic [8:0]  d_wd_src  [ND];
    logic [16:0] d_rem_next[ND][4];
    logic [7:0]  d_q_next  [ND][4];

    always_comb
    begin
        logic [16:0] dsh;
        for (int i = 0; i < 4; i++)
        begin
            d_rem_src[0][i] = t_next[i];
            d_q_src[0][i]   = '0;
        end
        d_wd_src[0] = m3_wd_reg;
        for (int j = 1; j < ND; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d_rem_src[j][i] = d_rem_reg[j-1][i];
                d_q_src[j][i]   = d_q_reg[j-1][i];
            end
            d_wd_src[j] = d_wd_reg[j-1];
        end
        for (int j = 0; j < ND; j++)
        begin
            dsh = 17'(d_wd_src[j]) << (ND - 1 - j);
            for (int i = 0; i < 4; i++)
            begin
                if (d_rem_src[j][i] >= dsh)
                begin
                    d_rem_next[j][i] = d_rem_src[j][i] - dsh;
                    d_q_next[j][i]   = {d_q_src[j][i][6:0], 1'b1};
                end
                else
                begin
                    d_rem_next[j][i] = d_rem_src[j][i];
                    d_q_next[j][i]   = {d_q_src[j][i][6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < ND; j++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    d_rem_reg[j][i] <= d_rem_next[j][i];
                    d_q_reg[j][i]   <= d_q_next[j][i];
                end
                d_wd_reg[j] <= d_wd_src[j];
            end
        end
    end

    assign red_out   = d_q_reg[ND-1][0];
    assign green_out = d_q_reg[ND-1][1];
    assign blue_out  = d_q_reg[ND-1][2];
    assign alpha_out = d_q_reg[ND-1][3];

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NH-1] |-> hq_reg[NH-1] < HUE_W'(360))
        else $error("hue out of range");

    a_weight_order: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_W] |-> (w_wn_reg <= w_wd_reg) && (w_wd_reg != '0))
        else $error("blend weight above one or zero denominator");

    a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_DIV0] |-> (18'(d_q_reg[0][3]) << 7) + 18'(d_rem_reg[0][3])
                           < (18'(d_wd_reg[0]) << 8))
        else $error("blend quotient exceeds 8 bits");

    a_grey_corr: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_M3] |-> 25'(m3_qe_reg) * 25'd255 <= m3_p_reg)
        else $error("reciprocal estimate too large");

    a_m_chain: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_M1] && adv |=> v_reg[ST_M2])
        else $error("pipeline valid chain broken");

endmodule

@@ rtl/selective_grayscale_pixel_top.sv @@
// Top level of the selective grayscale pixel block: config registers,
// front end, queue and back end. Depends on sgp_pkg, sgp_front, sgp_fifo, sgp_back.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+------------------
//  in      | red_in green_in blue_in alpha_in          | in_valid/in_ready
//  out     | red_out green_out blue_out alpha_out      | out_valid/out_ready
//  cfg     | cfg_index cfg_data                        | cfg_we, no wait
//
// One pixel per clock sustained while out_ready is held high; each input word
// passes one front register, one queue entry and 21 back stages (9 hue
// divide bits, 4 weight, luminance and grey stages, 8 blend divide bits).
// Reset clears the valid state and loads target_hue 0, hue_spread 30.
// An output stall freezes the back pipeline; the queue absorbs the front.
module selective_grayscale_pixel_top #(
    parameter int QUEUE_DEPTH = sgp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [sgp_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sgp_pkg::CH_W-1:0]    red_in,
    input  logic [sgp_pkg::CH_W-1:0]    green_in,
    input  logic [sgp_pkg::CH_W-1:0]    blue_in,
    input  logic [sgp_pkg::CH_W-1:0]    alpha_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sgp_pkg::CH_W-1:0]    red_out,
    output logic [sgp_pkg::CH_W-1:0]    green_out,
    output logic [sgp_pkg::CH_W-1:0]    blue_out,
    output logic [sgp_pkg::CH_W-1:0]    alpha_out
);

    logic [sgp_pkg::CFG_W-1:0] target_hue_reg;
    logic [sgp_pkg::CFG_W-1:0] hue_spread_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_hue_reg <= sgp_pkg::TARGET_HUE_RST;
            hue_spread_reg <= sgp_pkg::HUE_SPREAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (sgp_pkg::cfg_index_t'(cfg_index))
                sgp_pkg::CFG_TARGET_HUE: target_hue_reg <= cfg_data;
                sgp_pkg::CFG_HUE_SPREAD: hue_spread_reg <= cfg_data;
            endcase
        end
    end

    logic               fq_valid, fq_ready;
    sgp_pkg::sgp_item_t fq_item;
    logic               qb_valid, qb_ready;
    sgp_pkg::sgp_item_t qb_item;

    sgp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .alpha_in (alpha_in),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    sgp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    sgp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (qb_valid),
        .s_ready    (qb_ready),
        .s_item     (qb_item),
        .target_hue (target_hue_reg),
        .hue_spread (hue_spread_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out)
    );

endmodule
